// File: rtl/json_token_scanner_macros.svh
// assertion macros for the json token scanner
`ifndef JSON_TOKEN_SCANNER_MACROS_SVH
`define JSON_TOKEN_SCANNER_MACROS_SVH

`ifndef SYNTHESIS

`define JTS_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define JTS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define JTS_ASSERT_SAME(name, ante, cons, msg)

`define JTS_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// File: rtl/jts_pkg.sv
package jts_pkg;

    localparam int unsigned COUNT_WIDTH_DEF = 32;
    localparam int unsigned OUT_W = 32;
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned PTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);
    localparam int unsigned NCAND = 4;

    // token codes
    localparam logic [3:0] TOK_LBRACE  = 4'd0;
    localparam logic [3:0] TOK_RBRACE  = 4'd1;
    localparam logic [3:0] TOK_LBRACK  = 4'd2;
    localparam logic [3:0] TOK_RBRACK  = 4'd3;
    localparam logic [3:0] TOK_COMMA   = 4'd4;
    localparam logic [3:0] TOK_COLON   = 4'd5;
    localparam logic [3:0] TOK_STRING  = 4'd6;
    localparam logic [3:0] TOK_NUMBER  = 4'd7;
    localparam logic [3:0] TOK_TRUE    = 4'd8;
    localparam logic [3:0] TOK_EOF     = 4'd11;
    localparam logic [3:0] TOK_INVALID = 4'd12;

    // literal kinds
    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_E   = 8'h45;
    localparam logic [7:0] CH_UC_F   = 8'h46;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_E   = 8'h65;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_L   = 8'h6C;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_S   = 8'h73;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [7:0] LIT_TEXT [4][5] = '{
        '{CH_LC_T, CH_LC_R, CH_LC_U, CH_LC_E, CH_NUL},
        '{CH_LC_F, CH_LC_A, CH_LC_L, CH_LC_S, CH_LC_E},
        '{CH_LC_N, CH_LC_U, CH_LC_L, CH_LC_L, CH_NUL},
        '{CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}
    };

    localparam logic [2:0] LIT_LEN [4] = '{3'd4, 3'd5, 3'd4, 3'd0};

    typedef struct packed {
        logic [3:0]       tok_type;
        logic [OUT_W-1:0] start_offset;
        logic [OUT_W-1:0] token_length;
        logic [OUT_W-1:0] line_number;
        logic [OUT_W-1:0] column_number;
        logic             last_result;
    } res_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return is_digit(b) || ((b >= CH_LC_A) && (b <= CH_LC_F))
            || ((b >= CH_UC_A) && (b <= CH_UC_F));
    endfunction

    function automatic logic is_delim(input logic [7:0] b);
        return (b == CH_NUL) || ((b >= CH_TAB) && (b <= CH_CR)) || (b == CH_SPACE)
            || (b == CH_COMMA) || (b == CH_RBRACK) || (b == CH_RBRACE);
    endfunction

    function automatic logic is_escape(input logic [7:0] b);
        return (b == CH_QUOTE) || (b == CH_BSLASH) || (b == CH_SLASH) || (b == CH_LC_B)
            || (b == CH_LC_F) || (b == CH_LC_N) || (b == CH_LC_R) || (b == CH_LC_T);
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] idx);
        logic [7:0] c;
        c = CH_NUL;
        if (idx < 3'd5)
        begin
            c = LIT_TEXT[kind][idx];
        end
        return c;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] kind);
        return LIT_LEN[kind];
    endfunction

endpackage

// File: rtl/json_token_scanner.sv
// JSON text enters one byte per request; each request may also mark end of text. A request
// is held in an input register, is scanned there and its tokens (none to three) go into a
// four-entry result queue that drives the token port, one token per cycle while token_stall
// is low. A request is taken every cycle while the queue has room for its tokens, so the
// scanner runs at one byte per cycle when each byte yields at most one token and the port
// is not stalled. The first token of a request passes the input register, then the queue.
// Offsets wrap and line and column counts saturate at COUNT_WIDTH bits, then are cut or
// zero-extended to 32 bits. After an error one invalid token is sent and later bytes are
// only counted until end of text; the eof token returns the scanner to its reset state.
`include "json_token_scanner_macros.svh"

module json_token_scanner #(
    parameter int unsigned COUNT_WIDTH = jts_pkg::COUNT_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        text_valid,
    output logic        text_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_input,
    output logic        token_valid,
    input  logic        token_stall,
    output logic [3:0]  token_type,
    output logic [31:0] start_offset,
    output logic [31:0] token_length,
    output logic [31:0] line_number,
    output logic [31:0] column_number,
    output logic        last_result
);

    localparam int unsigned CW = COUNT_WIDTH;
    localparam int unsigned OUT_W = jts_pkg::OUT_W;
    localparam int unsigned EXT_W = (CW > OUT_W) ? CW : OUT_W;
    localparam int unsigned PTR_W = jts_pkg::PTR_W;
    localparam int unsigned QCNT_W = jts_pkg::QCNT_W;
    localparam int unsigned NCAND = jts_pkg::NCAND;

    typedef enum logic [3:0] {
        M_IDLE,
        M_STR,
        M_ESC,
        M_HEX,
        M_NSIGN,
        M_NZERO,
        M_NINT,
        M_NFRAC0,
        M_NFRAC,
        M_NEXP0,
        M_NEXPS,
        M_NEXP,
        M_LIT,
        M_HOLD
    } mode_t;

    function automatic logic [OUT_W-1:0] cut32(input logic [CW-1:0] v);
        return OUT_W'(EXT_W'(v));
    endfunction

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v == '1) ? v : v + CW'(1);
    endfunction

    function automatic jts_pkg::res_t mk(
        input logic [3:0]    t,
        input logic [CW-1:0] off,
        input logic [CW-1:0] len,
        input logic [CW-1:0] line,
        input logic [CW-1:0] col
    );
        jts_pkg::res_t r;
        r.tok_type = t;
        r.start_offset = cut32(off);
        r.token_length = cut32(len);
        r.line_number = cut32(line);
        r.column_number = cut32(col);
        r.last_result = 1'b0;
        return r;
    endfunction

    // input register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_present_reg;
    logic       in_eoi_reg;
    logic       text_take;
    logic       take;

    // scanner state
    mode_t         mode_reg;
    mode_t         mode_next;
    logic [CW-1:0] offset_reg;
    logic [CW-1:0] offset_next;
    logic [CW-1:0] line_reg;
    logic [CW-1:0] line_next;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic          after_cr_reg;
    logic          after_cr_next;
    logic [CW-1:0] tok_off_reg;
    logic [CW-1:0] tok_off_next;
    logic [CW-1:0] tok_line_reg;
    logic [CW-1:0] tok_line_next;
    logic [CW-1:0] tok_col_reg;
    logic [CW-1:0] tok_col_next;
    logic [1:0]    kind_reg;
    logic [1:0]    kind_next;
    logic [2:0]    match_reg;
    logic [2:0]    match_next;

    // result queue
    jts_pkg::res_t     q_mem [jts_pkg::QDEPTH];
    logic [PTR_W-1:0]  q_rd_reg;
    logic [PTR_W-1:0]  q_rd_next;
    logic [PTR_W-1:0]  q_wr_reg;
    logic [PTR_W-1:0]  q_wr_next;
    logic [QCNT_W-1:0] q_count_reg;
    logic [QCNT_W-1:0] q_count_next;
    logic              pop;
    jts_pkg::res_t     head;

    // idle decode of the current byte
    logic          idle_v;
    jts_pkg::res_t idle_res;
    mode_t         idle_mode;
    logic          idle_begin;
    logic [1:0]    idle_kind;
    logic [2:0]    idle_match;

    // scan results
    logic [7:0]    b;
    mode_t         s_mode;
    logic [CW-1:0] s_tok_off;
    logic [CW-1:0] s_tok_line;
    logic [CW-1:0] s_tok_col;
    logic [1:0]    s_kind;
    logic [2:0]    s_match;
    logic          fail_cur;
    logic          fail_tok;
    logic          fin_num;
    logic          fin_lit;
    logic          str_done;
    logic          rescan;
    logic [2:0]    cur_lit_len;
    logic [2:0]    end_lit_len;
    logic [CW-1:0] p_off;
    logic [CW-1:0] p_line;
    logic [CW-1:0] p_col;
    logic          p_cr;

    jts_pkg::res_t     cand [NCAND];
    jts_pkg::res_t     cand_fin [NCAND];
    logic [NCAND-1:0]  cand_v;
    logic [PTR_W-1:0]  slot [NCAND];
    logic [QCNT_W-1:0] n_res;

    assign b = in_byte_reg;

    always_comb
    begin
        idle_v = 1'b0;
        idle_res = mk(jts_pkg::TOK_INVALID, '0, '0, line_reg, col_reg);
        idle_mode = M_IDLE;
        idle_begin = 1'b0;
        idle_kind = kind_reg;
        idle_match = match_reg;
        unique case (b)
            jts_pkg::CH_SPACE, jts_pkg::CH_TAB, jts_pkg::CH_LF, jts_pkg::CH_CR:
            begin
                idle_mode = M_IDLE;
            end
            jts_pkg::CH_LBRACE:
            begin
                idle_v = 1'b1;
                idle_res = mk(jts_pkg::TOK_LBRACE, offset_reg, CW'(1), line_reg, col_reg);
            end
            jts_pkg::CH_RBRACE:
            begin
                idle_v = 1'b1;
                idle_res = mk(jts_pkg::TOK_RBRACE, offset_reg, CW'(1), line_reg, col_reg);
            end
            jts_pkg::CH_LBRACK:
            begin
                idle_v = 1'b1;
                idle_res = mk(jts_pkg::TOK_LBRACK, offset_reg, CW'(1), line_reg, col_reg);
            end
            jts_pkg::CH_RBRACK:
            begin
                idle_v = 1'b1;
                idle_res = mk(jts_pkg::TOK_RBRACK, offset_reg, CW'(1), line_reg, col_reg);
            end
            jts_pkg::CH_COMMA:
            begin
                idle_v = 1'b1;
                idle_res = mk(jts_pkg::TOK_COMMA, offset_reg, CW'(1), line_reg, col_reg);
            end
            jts_pkg::CH_COLON:
            begin
                idle_v = 1'b1;
                idle_res = mk(jts_pkg::TOK_COLON, offset_reg, CW'(1), line_reg, col_reg);
            end
            jts_pkg::CH_QUOTE:
            begin
                idle_begin = 1'b1;
                idle_mode = M_STR;
            end
            jts_pkg::CH_MINUS:
            begin
                idle_begin = 1'b1;
                idle_mode = M_NSIGN;
            end
            jts_pkg::CH_ZERO:
            begin
                idle_begin = 1'b1;
                idle_mode = M_NZERO;
            end
            jts_pkg::CH_LC_T:
            begin
                idle_begin = 1'b1;
                idle_mode = M_LIT;
                idle_kind = jts_pkg::LIT_TRUE;
                idle_match = 3'd1;
            end
            jts_pkg::CH_LC_F:
            begin
                idle_begin = 1'b1;
                idle_mode = M_LIT;
                idle_kind = jts_pkg::LIT_FALSE;
                idle_match = 3'd1;
            end
            jts_pkg::CH_LC_N:
            begin
                idle_begin = 1'b1;
                idle_mode = M_LIT;
                idle_kind = jts_pkg::LIT_NULL;
                idle_match = 3'd1;
            end
            default:
            begin
                if (jts_pkg::is_digit(b))
                begin
                    idle_begin = 1'b1;
                    idle_mode = M_NINT;
                end
                else
                begin
                    idle_v = 1'b1;
                    idle_mode = M_HOLD;
                end
            end
        endcase
    end

    always_comb
    begin
        s_mode = mode_reg;
        s_tok_off = tok_off_reg;
        s_tok_line = tok_line_reg;
        s_tok_col = tok_col_reg;
        s_kind = kind_reg;
        s_match = match_reg;
        fail_cur = 1'b0;
        fail_tok = 1'b0;
        fin_num = 1'b0;
        fin_lit = 1'b0;
        str_done = 1'b0;
        rescan = 1'b0;
        cur_lit_len = jts_pkg::lit_len(kind_reg);
        cand_v = '0;
        cand[0] = idle_res;
        cand[1] = idle_res;

        if (in_present_reg)
        begin
            unique case (mode_reg)
                M_IDLE:
                begin
                    cand_v[0] = idle_v;
                    s_mode = idle_mode;
                    s_kind = idle_kind;
                    s_match = idle_match;
                    if (idle_begin)
                    begin
                        s_tok_off = offset_reg;
                        s_tok_line = line_reg;
                        s_tok_col = col_reg;
                    end
                end
                M_STR:
                begin
                    if (b == jts_pkg::CH_QUOTE)
                    begin
                        str_done = 1'b1;
                    end
                    else if (b == jts_pkg::CH_BSLASH)
                    begin
                        s_mode = M_ESC;
                    end
                    else if ((b < jts_pkg::CH_SPACE) && (b != jts_pkg::CH_TAB))
                    begin
                        fail_cur = 1'b1;
                    end
                end
                M_ESC:
                begin
                    if (jts_pkg::is_escape(b))
                    begin
                        s_mode = M_STR;
                    end
                    else if (b == jts_pkg::CH_LC_U)
                    begin
                        s_mode = M_HEX;
                        s_match = 3'd0;
                    end
                    else
                    begin
                        fail_cur = 1'b1;
                    end
                end
                M_HEX:
                begin
                    if (!jts_pkg::is_hex(b))
                    begin
                        fail_cur = 1'b1;
                    end
                    else if (match_reg >= 3'd3)
                    begin
                        s_match = 3'd0;
                        s_mode = M_STR;
                    end
                    else
                    begin
                        s_match = match_reg + 3'd1;
                    end
                end
                M_NSIGN:
                begin
                    if (b == jts_pkg::CH_ZERO)
                    begin
                        s_mode = M_NZERO;
                    end
                    else if (jts_pkg::is_digit(b))
                    begin
                        s_mode = M_NINT;
                    end
                    else
                    begin
                        fail_cur = 1'b1;
                    end
                end
                M_NZERO, M_NINT:
                begin
                    if (jts_pkg::is_digit(b))
                    begin
                        fail_cur = (mode_reg == M_NZERO);
                    end
                    else if (b == jts_pkg::CH_DOT)
                    begin
                        s_mode = M_NFRAC0;
                    end
                    else if ((b == jts_pkg::CH_LC_E) || (b == jts_pkg::CH_UC_E))
                    begin
                        s_mode = M_NEXP0;
                    end
                    else
                    begin
                        fin_num = 1'b1;
                    end
                end
                M_NFRAC0:
                begin
                    if (jts_pkg::is_digit(b))
                    begin
                        s_mode = M_NFRAC;
                    end
                    else
                    begin
                        fail_cur = 1'b1;
                    end
                end
                M_NFRAC:
                begin
                    if ((b == jts_pkg::CH_LC_E) || (b == jts_pkg::CH_UC_E))
                    begin
                        s_mode = M_NEXP0;
                    end
                    else if (!jts_pkg::is_digit(b))
                    begin
                        fin_num = 1'b1;
                    end
                end
                M_NEXP0:
                begin
                    if ((b == jts_pkg::CH_PLUS) || (b == jts_pkg::CH_MINUS))
                    begin
                        s_mode = M_NEXPS;
                    end
                    else if (jts_pkg::is_digit(b))
                    begin
                        s_mode = M_NEXP;
                    end
                    else
                    begin
                        fail_cur = 1'b1;
                    end
                end
                M_NEXPS:
                begin
                    if (jts_pkg::is_digit(b))
                    begin
                        s_mode = M_NEXP;
                    end
                    else
                    begin
                        fail_cur = 1'b1;
                    end
                end
                M_NEXP:
                begin
                    if (!jts_pkg::is_digit(b))
                    begin
                        fin_num = 1'b1;
                    end
                end
                M_LIT:
                begin
                    if (match_reg < cur_lit_len)
                    begin
                        if (b == jts_pkg::lit_char(kind_reg, match_reg))
                        begin
                            s_match = match_reg + 3'd1;
                        end
                        else
                        begin
                            fail_tok = 1'b1;
                        end
                    end
                    else
                    begin
                        fin_lit = 1'b1;
                    end
                end
                M_HOLD:
                begin
                    s_mode = M_HOLD;
                end
                default:
                begin
                    s_mode = M_HOLD;
                end
            endcase
        end

        // number or literal ended by this byte
        if (fin_num || fin_lit)
        begin
            if (jts_pkg::is_delim(b))
            begin
                cand_v[0] = 1'b1;
                if (fin_num)
                begin
                    cand[0] = mk(jts_pkg::TOK_NUMBER, tok_off_reg, offset_reg - tok_off_reg,
                        tok_line_reg, tok_col_reg);
                end
                else
                begin
                    cand[0] = mk(jts_pkg::TOK_TRUE + {2'b00, kind_reg}, tok_off_reg,
                        CW'(cur_lit_len), tok_line_reg, tok_col_reg);
                end
                s_mode = M_IDLE;
                rescan = 1'b1;
            end
            else
            begin
                fail_cur = 1'b1;
            end
        end
        if (str_done)
        begin
            cand_v[0] = 1'b1;
            cand[0] = mk(jts_pkg::TOK_STRING, tok_off_reg,
                offset_reg + CW'(1) - tok_off_reg, tok_line_reg, tok_col_reg);
            s_mode = M_IDLE;
        end
        if (fail_cur)
        begin
            cand_v[0] = 1'b1;
            cand[0] = mk(jts_pkg::TOK_INVALID, '0, '0, line_reg, col_reg);
            s_mode = M_HOLD;
        end
        if (fail_tok)
        begin
            cand_v[0] = 1'b1;
            cand[0] = mk(jts_pkg::TOK_INVALID, '0, '0, tok_line_reg, tok_col_reg);
            s_mode = M_HOLD;
        end

        // delimiter scanned again between tokens
        if (rescan)
        begin
            cand_v[1] = idle_v;
            s_mode = idle_mode;
        end
    end

    always_comb
    begin
        p_off = offset_reg;
        p_line = line_reg;
        p_col = col_reg;
        p_cr = after_cr_reg;
        if (in_present_reg)
        begin
            p_off = offset_reg + CW'(1);
            if (after_cr_reg && (b == jts_pkg::CH_LF))
            begin
                p_cr = 1'b0;
            end
            else if ((b == jts_pkg::CH_LF) || (b == jts_pkg::CH_CR))
            begin
                p_line = sat_inc(line_reg);
                p_col = CW'(1);
                p_cr = (b == jts_pkg::CH_CR);
            end
            else
            begin
                p_col = sat_inc(col_reg);
                p_cr = 1'b0;
            end
        end
    end

    // end of text
    always_comb
    begin
        end_lit_len = jts_pkg::lit_len(s_kind);
        cand[2] = mk(jts_pkg::TOK_INVALID, '0, '0, p_line, p_col);
        cand[3] = mk(jts_pkg::TOK_EOF, p_off, '0, p_line, p_col);
        cand_v[2] = 1'b0;
        cand_v[3] = in_eoi_reg;
        if (in_eoi_reg)
        begin
            unique case (s_mode)
                M_NZERO, M_NINT, M_NFRAC, M_NEXP:
                begin
                    cand_v[2] = 1'b1;
                    cand[2] = mk(jts_pkg::TOK_NUMBER, s_tok_off, p_off - s_tok_off,
                        s_tok_line, s_tok_col);
                end
                M_STR, M_ESC, M_HEX, M_NSIGN, M_NFRAC0, M_NEXP0, M_NEXPS:
                begin
                    cand_v[2] = 1'b1;
                end
                M_LIT:
                begin
                    cand_v[2] = 1'b1;
                    if ((s_match == end_lit_len) && (end_lit_len != 3'd0))
                    begin
                        cand[2] = mk(jts_pkg::TOK_TRUE + {2'b00, s_kind}, s_tok_off,
                            CW'(end_lit_len), s_tok_line, s_tok_col);
                    end
                    else
                    begin
                        cand[2] = mk(jts_pkg::TOK_INVALID, '0, '0, s_tok_line, s_tok_col);
                    end
                end
                default:
                begin
                    cand_v[2] = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        if (in_eoi_reg)
        begin
            mode_next = M_IDLE;
            offset_next = '0;
            line_next = CW'(1);
            col_next = CW'(1);
            after_cr_next = 1'b0;
            tok_off_next = '0;
            tok_line_next = CW'(1);
            tok_col_next = CW'(1);
            kind_next = jts_pkg::LIT_TRUE;
            match_next = 3'd0;
        end
        else
        begin
            mode_next = s_mode;
            offset_next = p_off;
            line_next = p_line;
            col_next = p_col;
            after_cr_next = p_cr;
            tok_off_next = s_tok_off;
            tok_line_next = s_tok_line;
            tok_col_next = s_tok_col;
            kind_next = s_kind;
            match_next = s_match;
        end
    end

    // pack the tokens of one request into consecutive queue slots
    always_comb
    begin
        logic [PTR_W-1:0]  pos;
        logic [QCNT_W-1:0] cnt;
        logic              seen;
        pos = '0;
        cnt = '0;
        seen = 1'b0;
        for (int i = 0; i < NCAND; i++)
        begin
            slot[i] = q_wr_reg + pos;
            if (cand_v[i])
            begin
                pos = pos + PTR_W'(1);
                cnt = cnt + QCNT_W'(1);
            end
        end
        for (int i = NCAND - 1; i >= 0; i--)
        begin
            cand_fin[i] = cand[i];
            cand_fin[i].last_result = cand_v[i] && !seen;
            seen = seen || cand_v[i];
        end
        n_res = cnt;
    end

    assign take = in_valid_reg
        && (({1'b0, q_count_reg} + {1'b0, n_res}) <= (QCNT_W + 1)'(jts_pkg::QDEPTH));
    assign text_stall = in_valid_reg && !take;
    assign text_take = text_valid && !text_stall;
    assign in_valid_next = text_take || (in_valid_reg && !take);

    assign token_valid = (q_count_reg != '0);
    assign pop = token_valid && !token_stall;
    assign q_rd_next = q_rd_reg + PTR_W'(pop);
    assign q_wr_next = take ? q_wr_reg + PTR_W'(n_res) : q_wr_reg;
    assign q_count_next = q_count_reg + (take ? n_res : '0) - QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            q_rd_reg <= '0;
            q_wr_reg <= '0;
            q_count_reg <= '0;
            mode_reg <= M_IDLE;
            offset_reg <= '0;
            line_reg <= CW'(1);
            col_reg <= CW'(1);
            after_cr_reg <= 1'b0;
            tok_off_reg <= '0;
            tok_line_reg <= CW'(1);
            tok_col_reg <= CW'(1);
            kind_reg <= jts_pkg::LIT_TRUE;
            match_reg <= 3'd0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            q_rd_reg <= q_rd_next;
            q_wr_reg <= q_wr_next;
            q_count_reg <= q_count_next;
            if (take)
            begin
                mode_reg <= mode_next;
                offset_reg <= offset_next;
                line_reg <= line_next;
                col_reg <= col_next;
                after_cr_reg <= after_cr_next;
                tok_off_reg <= tok_off_next;
                tok_line_reg <= tok_line_next;
                tok_col_reg <= tok_col_next;
                kind_reg <= kind_next;
                match_reg <= match_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_take)
        begin
            in_byte_reg <= data_byte;
            in_present_reg <= byte_present;
            in_eoi_reg <= end_of_input;
        end
        if (take)
        begin
            for (int i = 0; i < NCAND; i++)
            begin
                if (cand_v[i])
                begin
                    q_mem[slot[i]] <= cand_fin[i];
                end
            end
        end
    end

    assign head = q_mem[q_rd_reg];
    assign token_type = head.tok_type;
    assign start_offset = head.start_offset;
    assign token_length = head.token_length;
    assign line_number = head.line_number;
    assign column_number = head.column_number;
    assign last_result = head.last_result;

    `JTS_ASSERT_NEXT(a_eof_clears_state, take && in_eoi_reg, (mode_reg == M_IDLE) && (offset_reg == '0) && (line_reg == CW'(1)), "scanner state not cleared after end of text")
    `JTS_ASSERT_SAME(a_eof_token_written, take && in_eoi_reg, cand_v[3] && (n_res != '0), "end of text without eof token")
    `JTS_ASSERT_SAME(a_hold_is_silent, take && (mode_reg == M_HOLD) && !in_eoi_reg, n_res == '0, "token produced after an error")
    `JTS_ASSERT_NEXT(a_queue_drains, pop && (q_count_reg == QCNT_W'(1)) && !take, !token_valid, "queue still valid after last token taken")

endmodule
